/* rtl/rit_pkg.sv */
// rit_pkg: field widths, the unity index constant and the list entry type
// for the refraction index tracker; depends on nothing
`default_nettype none
package rit_pkg;

    localparam int ID_W  = 8;
    localparam int IDX_W = 16;

    // 1.0 in unsigned q4.12
    localparam logic [IDX_W-1:0] INDEX_ONE = 16'd4096;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [IDX_W-1:0] idx;
    } t_entry;

endpackage
`default_nettype wire

/* rtl/rit_in_if.sv */
// rit_in_if: valid/ready channel for one intersection item
// depends on rit_pkg for field widths
`default_nettype none
interface rit_in_if;
    logic                     valid;
    logic                     ready;
    logic                     first;
    logic [rit_pkg::ID_W-1:0]  object_id;
    logic [rit_pkg::IDX_W-1:0] refr_index;
    logic                     is_hit;

    modport source (output valid, first, object_id, refr_index, is_hit, input ready);
    modport sink   (input valid, first, object_id, refr_index, is_hit, output ready);
endinterface
`default_nettype wire

/* rtl/rit_out_if.sv */
// rit_out_if: valid/ready channel for one n1/n2 result
// depends on rit_pkg for field widths
`default_nettype none
interface rit_out_if;
    logic                     valid;
    logic                     ready;
    logic [rit_pkg::IDX_W-1:0] n1;
    logic [rit_pkg::IDX_W-1:0] n2;
    logic                     overflow;

    modport source (output valid, n1, n2, overflow, input ready);
    modport sink   (input valid, n1, n2, overflow, output ready);
endinterface
`default_nettype wire

/* rtl/refraction_index_tracker_unit.sv */
// refraction_index_tracker_unit: ordered container list with a shared id compare
// depends on rit_pkg, rit_in_if and rit_out_if
// per item: the search reads and compares each entry in turn; a miss appends (or drops
//   when full), a match shifts later entries down and rereads the top if the last one went
// throughput: one item at a time, ready only while the sequencer is idle
// an item marked first clears the list; an item after the hit is taken and ignored
// reset: synchronous active low, list empty, result register empty
`default_nettype none
module refraction_index_tracker_unit #(
    parameter int MAX_CONTAINERS = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    rit_in_if.sink    i_in,
    rit_out_if.source o_out
);
    import rit_pkg::*;

    localparam int AW = $clog2(MAX_CONTAINERS);
    localparam int CW = $clog2(MAX_CONTAINERS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SH_RD,
        S_SH_WR,
        S_TOP_RD,
        S_TOP_WAIT,
        S_FIN
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_pos;
    logic              r_hit_done;
    logic              r_ovf;
    logic              r_was_last;
    logic [IDX_W-1:0]  r_top;
    logic [ID_W-1:0]   r_id;
    logic [IDX_W-1:0]  r_idx;
    logic              r_is_hit;
    logic [IDX_W-1:0]  r_n1;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_n1;
    logic [IDX_W-1:0]  r_out_n2;
    logic              r_out_ovf;

    t_entry            r_mem [MAX_CONTAINERS];
    t_entry            r_rd_data;

    logic [CW-1:0]     w_pos_inc;
    logic [CW-1:0]     w_cnt_dec;
    logic [AW-1:0]     w_rd_addr;
    logic              w_we;
    logic [AW-1:0]     w_wa;
    t_entry            w_wd;
    logic              w_accept;
    logic              w_out_free;

    assign w_pos_inc  = r_pos + 1'b1;
    assign w_cnt_dec  = r_count - 1'b1;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.n1       = r_out_n1;
    assign o_out.n2       = r_out_n2;
    assign o_out.overflow = r_out_ovf;

    // ram address and write control
    always_comb begin
        w_rd_addr = r_pos[AW-1:0];
        w_we      = 1'b0;
        w_wa      = r_count[AW-1:0];
        w_wd.id   = r_id;
        w_wd.idx  = r_idx;
        case (r_state)
            S_SH_RD: begin
                w_rd_addr = w_pos_inc[AW-1:0];
            end
            S_SH_WR: begin
                w_we = 1'b1;
                w_wa = r_pos[AW-1:0];
                w_wd = r_rd_data;
            end
            S_TOP_RD: begin
                w_rd_addr = w_cnt_dec[AW-1:0];
            end
            S_SRCH_RD: begin
                w_we = (r_pos >= r_count) && (r_count < CW'(MAX_CONTAINERS));
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_hit_done  <= 1'b0;
            r_ovf       <= 1'b0;
            r_was_last  <= 1'b0;
            r_top       <= INDEX_ONE;
            r_is_hit    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && !(r_state == S_FIN && r_is_hit)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_id     <= i_in.object_id;
                        r_idx    <= i_in.refr_index;
                        r_is_hit <= i_in.is_hit;
                        r_pos    <= '0;
                        r_n1     <= i_in.first ? INDEX_ONE : r_top;
                        if (i_in.first) begin
                            r_count    <= '0;
                            r_top      <= INDEX_ONE;
                            r_ovf      <= 1'b0;
                            r_hit_done <= 1'b0;
                            r_state    <= S_SRCH_RD;
                        end else if (!r_hit_done) begin
                            r_state <= S_SRCH_RD;
                        end
                    end
                end
                S_SRCH_RD: begin
                    if (r_pos >= r_count) begin
                        // not in the list: append or drop
                        if (r_count < CW'(MAX_CONTAINERS)) begin
                            r_count <= w_pos_inc;
                            r_top   <= r_idx;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_SRCH_CMP;
                    end
                end
                S_SRCH_CMP: begin
                    if (r_rd_data.id == r_id) begin
                        r_was_last <= (r_pos == w_cnt_dec);
                        r_state    <= S_SH_RD;
                    end else begin
                        r_pos   <= w_pos_inc;
                        r_state <= S_SRCH_RD;
                    end
                end
                S_SH_RD: begin
                    if (w_pos_inc >= r_count) begin
                        r_count <= w_cnt_dec;
                        if (w_cnt_dec == '0) begin
                            r_top   <= INDEX_ONE;
                            r_state <= S_FIN;
                        end else if (r_was_last) begin
                            r_state <= S_TOP_RD;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_state <= S_SH_WR;
                    end
                end
                S_SH_WR: begin
                    r_pos   <= w_pos_inc;
                    r_state <= S_SH_RD;
                end
                S_TOP_RD: begin
                    r_state <= S_TOP_WAIT;
                end
                S_TOP_WAIT: begin
                    r_top   <= r_rd_data.idx;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_is_hit) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_n1    <= r_n1;
                        r_out_n2    <= r_top;
                        r_out_ovf   <= r_ovf;
                        r_hit_done  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // list never grows past its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_CONTAINERS))
        else $error("container count past capacity");

    // an empty list reports unity index
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_count == '0) |-> (r_top == INDEX_ONE))
        else $error("empty list with non-unity top index");

    // a first item clears the per-list flags
    a_first_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.first) |=> (!r_ovf && !r_hit_done && r_count == '0))
        else $error("first item did not clear the list");

    // a new result only follows a hit item
    a_result_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> r_hit_done)
        else $error("result without hit");

    // shift loop only runs after a match inside the list
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_WR) |-> (w_pos_inc < r_count))
        else $error("shift past end of list");

endmodule
`default_nettype wire
